// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the SHA-1 engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SHA1_AST_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SHA1_AST_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Condition that must never be seen.
`define SHA1_AST_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ===== rtl/sha1_pkg.sv =====
// Types, constants and helper functions of the SHA-1 engine.
package sha1_pkg;

	localparam int CHAIN_WORDS = 5;
	localparam int ROUNDS      = 80;
	localparam int SCHED_WORDS = 16;
	localparam int PHASE_LEN   = 20;

	localparam logic [5:0] LEN_POS  = 6'd56;   // first length byte in a block
	localparam logic [7:0] PAD_MARK = 8'h80;   // first pad byte
	localparam logic [2:0] LAST_IDX = 3'(CHAIN_WORDS - 1);

	// Input beat: one message byte or an empty item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       last;
	} in_beat_t;

	// Output beat: one digest word
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        final_word;
	} out_beat_t;

	// Controls of the schedule shift line
	typedef struct packed {
		logic       byte_en;
		logic [7:0] byte_val;
		logic       word_en;
	} sched_ctl_t;

	// Working variables of the compression
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} hash_vars_t;

	// Round function groups of 20 rounds
	typedef enum logic [1:0] {
		PH_CHOOSE = 2'd0,
		PH_PAR_LO = 2'd1,
		PH_MAJ    = 2'd2,
		PH_PAR_HI = 2'd3
	} phase_t;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ROUND = 5'b00010,
		ST_ADD   = 5'b00100,
		ST_PAD   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	// Initial chaining value
	function automatic logic [31:0] iv_word(input logic [2:0] idx);
		logic [31:0] v;
		case (idx)
			3'd0:    v = 32'h67452301;
			3'd1:    v = 32'hEFCDAB89;
			3'd2:    v = 32'h98BADCFE;
			3'd3:    v = 32'h10325476;
			3'd4:    v = 32'hC3D2E1F0;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	// Round constant per phase
	function automatic logic [31:0] round_k(input phase_t ph);
		logic [31:0] k;
		case (ph)
			PH_CHOOSE: k = 32'h5A827999;
			PH_PAR_LO: k = 32'h6ED9EBA1;
			PH_MAJ:    k = 32'h8F1BBCDC;
			PH_PAR_HI: k = 32'hCA62C1D6;
			default:   k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

// ===== rtl/sha1_sched.sv =====
// Block buffer and in-place message schedule as one 16-word shift line.
module sha1_sched (
	input  logic                  clk,
	input  sha1_pkg::sched_ctl_t  ctl,
	output logic [31:0]           w_cur
);

	logic [31:0] line_q [sha1_pkg::SCHED_WORDS];
	logic [31:0] mix;
	logic [31:0] w_new;

	// Next schedule word from the fixed taps
	assign mix   = line_q[13] ^ line_q[8] ^ line_q[2] ^ line_q[0];
	assign w_new = {mix[30:0], mix[31]};
	assign w_cur = line_q[0];

	// Bytes enter at the tail; rounds shift by one word
	always_ff @(posedge clk) begin
		if (ctl.byte_en) begin
			for (int i = 0; i < sha1_pkg::SCHED_WORDS - 1; i++) begin
				line_q[i] <= {line_q[i][23:0], line_q[i+1][31:24]};
			end
			line_q[sha1_pkg::SCHED_WORDS-1] <=
				{line_q[sha1_pkg::SCHED_WORDS-1][23:0], ctl.byte_val};
		end else if (ctl.word_en) begin
			for (int i = 0; i < sha1_pkg::SCHED_WORDS - 1; i++) begin
				line_q[i] <= line_q[i+1];
			end
			line_q[sha1_pkg::SCHED_WORDS-1] <= w_new;
		end
	end

endmodule

// ===== rtl/sha1_round.sv =====
// One SHA-1 round: the shared unit reused for all 80 rounds of a block.
module sha1_round (
	input  sha1_pkg::hash_vars_t  cur,
	input  logic [31:0]           w,
	input  sha1_pkg::phase_t      phase,
	output sha1_pkg::hash_vars_t  nxt
);

	logic [31:0] f;
	logic [31:0] t;

	// Round function select
	always_comb begin
		case (phase)
			sha1_pkg::PH_CHOOSE: f = (cur.b & cur.c) | (~cur.b & cur.d);
			sha1_pkg::PH_MAJ:    f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			sha1_pkg::PH_PAR_LO: f = cur.b ^ cur.c ^ cur.d;
			sha1_pkg::PH_PAR_HI: f = cur.b ^ cur.c ^ cur.d;
			default:             f = cur.b ^ cur.c ^ cur.d;
		endcase
	end

	assign t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + sha1_pkg::round_k(phase) + w;

	// Rotate the working variables
	assign nxt.a = t;
	assign nxt.b = cur.a;
	assign nxt.c = {cur.b[1:0], cur.b[31:2]};
	assign nxt.d = cur.c;
	assign nxt.e = cur.d;

endmodule

// ===== rtl/sha1_hash_engine.sv =====
// SHA-1 engine top level: byte intake, padding sequencer, rounds and digest output.
// Usage:
//   msg channel: one beat per message byte (byte_present = 1) or an empty
//   beat (byte_present = 0). last = 1 closes the message; a byte in that
//   beat is appended first. An empty last beat with no earlier bytes
//   hashes the empty message.
//   dig channel: after a last beat, five beats carry the digest words,
//   word_index 0 to 4, final_word set on the fifth.
// Sequence:
//   A byte that does not complete a block is taken while the engine stays
//   idle. A byte that completes a block triggers the load, 80 rounds through the
//   single round unit (one round a cycle) and the chaining add.
//   A last beat is followed by the pad bytes (to the end of the block, and
//   a second block when the length does not fit), the rounds and add
//   per padded block, then the five digest beats.
//   msg_stall is high whenever the engine is busy; one beat at a time.
// Reset: arst_n clears the sequencer and loads the initial chaining value;
//   the engine is ready on the first cycle after reset.
// Stall: while dig_stall is high the current digest word holds and the
//   engine waits; it returns to its initial state after the fifth word.
module sha1_hash_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 msg_valid,
	output logic                 msg_stall,
	input  sha1_pkg::in_beat_t   msg,
	output logic                 dig_valid,
	input  logic                 dig_stall,
	output sha1_pkg::out_beat_t  dig
);

	`include "assert_macros.svh"

	sha1_pkg::state_t      state_q;
	logic [31:0]           chain_q [sha1_pkg::CHAIN_WORDS];
	sha1_pkg::hash_vars_t  vars_q;
	sha1_pkg::hash_vars_t  vars_nxt;
	logic [6:0]            rnd_q;
	logic [5:0]            fill_q;
	logic [5:0]            fill_nxt;
	logic [60:0]           bcnt_q;      // message length in bytes
	logic [63:0]           bit_len;
	logic                  pad_q;       // message closed, padding in progress
	logic                  first_q;     // next pad byte is the marker
	logic                  lenhere_q;   // length goes into the current block
	logic [2:0]            idx_q;
	logic                  msg_acc;
	logic                  dig_acc;
	logic                  start_round;
	logic [7:0]            len_byte;
	logic [7:0]            pad_byte;
	logic [31:0]           w_cur;
	sha1_pkg::phase_t      phase;
	sha1_pkg::sched_ctl_t  sched_ctl;

	assign msg_stall = (state_q != sha1_pkg::ST_IDLE);
	assign dig_valid = (state_q == sha1_pkg::ST_OUT);
	assign msg_acc   = msg_valid && !msg_stall;
	assign dig_acc   = dig_valid && !dig_stall;
	assign fill_nxt  = fill_q + 6'd1;
	assign bit_len   = {bcnt_q, 3'b000};

	// Block becomes full: on a message byte or a pad byte
	assign start_round = (msg_acc && msg.byte_present && fill_nxt == 6'd0) ||
		(state_q == sha1_pkg::ST_PAD && fill_nxt == 6'd0);

	// Big-endian length byte for the current position
	always_comb begin
		case (fill_q[2:0])
			3'd0:    len_byte = bit_len[63:56];
			3'd1:    len_byte = bit_len[55:48];
			3'd2:    len_byte = bit_len[47:40];
			3'd3:    len_byte = bit_len[39:32];
			3'd4:    len_byte = bit_len[31:24];
			3'd5:    len_byte = bit_len[23:16];
			3'd6:    len_byte = bit_len[15:8];
			3'd7:    len_byte = bit_len[7:0];
			default: len_byte = 8'h00;
		endcase
	end

	// Pad byte: marker, zero fill, or length
	always_comb begin
		if (first_q) begin
			pad_byte = sha1_pkg::PAD_MARK;
		end else if (lenhere_q && fill_q >= sha1_pkg::LEN_POS) begin
			pad_byte = len_byte;
		end else begin
			pad_byte = 8'h00;
		end
	end

	// Schedule line control
	always_comb begin
		sched_ctl.byte_en  = (msg_acc && msg.byte_present) || (state_q == sha1_pkg::ST_PAD);
		sched_ctl.byte_val = (state_q == sha1_pkg::ST_PAD) ? pad_byte : msg.data_byte;
		sched_ctl.word_en  = (state_q == sha1_pkg::ST_ROUND);
	end

	// Round phase from the round counter
	always_comb begin
		if (rnd_q < 7'(sha1_pkg::PHASE_LEN)) begin
			phase = sha1_pkg::PH_CHOOSE;
		end else if (rnd_q < 7'(2 * sha1_pkg::PHASE_LEN)) begin
			phase = sha1_pkg::PH_PAR_LO;
		end else if (rnd_q < 7'(3 * sha1_pkg::PHASE_LEN)) begin
			phase = sha1_pkg::PH_MAJ;
		end else begin
			phase = sha1_pkg::PH_PAR_HI;
		end
	end

	sha1_sched u_sched (
		.clk   (clk),
		.ctl   (sched_ctl),
		.w_cur (w_cur)
	);

	sha1_round u_round (
		.cur   (vars_q),
		.w     (w_cur),
		.phase (phase),
		.nxt   (vars_nxt)
	);

	// Working variables
	always_ff @(posedge clk) begin
		if (start_round) begin
			vars_q.a <= chain_q[0];
			vars_q.b <= chain_q[1];
			vars_q.c <= chain_q[2];
			vars_q.d <= chain_q[3];
			vars_q.e <= chain_q[4];
		end else if (state_q == sha1_pkg::ST_ROUND) begin
			vars_q <= vars_nxt;
		end
	end

	// Sequencer, counters and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sha1_pkg::ST_IDLE;
			rnd_q     <= '0;
			fill_q    <= '0;
			bcnt_q    <= '0;
			pad_q     <= 1'b0;
			first_q   <= 1'b0;
			lenhere_q <= 1'b0;
			idx_q     <= '0;
			for (int i = 0; i < sha1_pkg::CHAIN_WORDS; i++) begin
				chain_q[i] <= sha1_pkg::iv_word(3'(i));
			end
		end else begin
			case (state_q)
				sha1_pkg::ST_IDLE: begin
					if (msg_acc) begin
						if (msg.byte_present) begin
							fill_q <= fill_nxt;
							bcnt_q <= bcnt_q + 61'd1;
						end
						if (msg.last) begin
							pad_q     <= 1'b1;
							first_q   <= 1'b1;
							lenhere_q <= 1'b0;
						end
						if (start_round) begin
							rnd_q   <= '0;
							state_q <= sha1_pkg::ST_ROUND;
						end else if (msg.last) begin
							state_q <= sha1_pkg::ST_PAD;
						end
					end
				end
				sha1_pkg::ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'(sha1_pkg::ROUNDS - 1)) begin
						state_q <= sha1_pkg::ST_ADD;
					end
				end
				sha1_pkg::ST_ADD: begin
					chain_q[0] <= chain_q[0] + vars_q.a;
					chain_q[1] <= chain_q[1] + vars_q.b;
					chain_q[2] <= chain_q[2] + vars_q.c;
					chain_q[3] <= chain_q[3] + vars_q.d;
					chain_q[4] <= chain_q[4] + vars_q.e;
					if (!pad_q) begin
						state_q <= sha1_pkg::ST_IDLE;
					end else if (lenhere_q) begin
						idx_q   <= '0;
						state_q <= sha1_pkg::ST_OUT;
					end else begin
						// length block follows
						lenhere_q <= 1'b1;
						state_q   <= sha1_pkg::ST_PAD;
					end
				end
				sha1_pkg::ST_PAD: begin
					fill_q  <= fill_nxt;
					first_q <= 1'b0;
					if (first_q) begin
						lenhere_q <= (fill_q < sha1_pkg::LEN_POS);
					end
					if (start_round) begin
						rnd_q   <= '0;
						state_q <= sha1_pkg::ST_ROUND;
					end
				end
				sha1_pkg::ST_OUT: begin
					if (dig_acc) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == sha1_pkg::LAST_IDX) begin
							// back to the initial state for the next message
							idx_q   <= '0;
							bcnt_q  <= '0;
							fill_q  <= '0;
							pad_q   <= 1'b0;
							state_q <= sha1_pkg::ST_IDLE;
							for (int i = 0; i < sha1_pkg::CHAIN_WORDS; i++) begin
								chain_q[i] <= sha1_pkg::iv_word(3'(i));
							end
						end
					end
				end
				default: begin
					state_q <= sha1_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Digest beat
	always_comb begin
		dig.digest_word = 32'h0;
		for (int i = 0; i < sha1_pkg::CHAIN_WORDS; i++) begin
			if (idx_q == 3'(i)) begin
				dig.digest_word = chain_q[i];
			end
		end
		dig.word_index = idx_q;
		dig.final_word = (idx_q == sha1_pkg::LAST_IDX);
	end

	// Checks
	`SHA1_AST_NEVER(a_no_overlap, msg_acc && dig_valid, "message beat taken while digest pending")
	`SHA1_AST_IMP(a_rnd_range, state_q == sha1_pkg::ST_ROUND, rnd_q < 7'(sha1_pkg::ROUNDS), "round counter out of range")
	`SHA1_AST_NXT(a_rounds_run, state_q == sha1_pkg::ST_ROUND && rnd_q != 7'(sha1_pkg::ROUNDS - 1), state_q == sha1_pkg::ST_ROUND, "compression left early")
	`SHA1_AST_NXT(a_restart, dig_acc && dig.final_word, state_q == sha1_pkg::ST_IDLE && fill_q == 6'd0 && bcnt_q == 61'd0, "engine not restarted after digest")

endmodule
